>>> hdl/unt_pkg.sv
package unt_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int CntW         = $clog2(TableEntries + 1);
  localparam int HeadW        = 64;
  localparam int TailW        = 8;
  localparam int NameW        = HeadW + TailW;

  // Request modes
  localparam logic [1:0] ModeCreate = 2'd0;
  localparam logic [1:0] ModeDelete = 2'd1;
  localparam logic [1:0] ModeSearch = 2'd2;
  localparam logic [1:0] ModeList   = 2'd3;

  // Result status codes
  localparam logic [2:0] StCreated  = 3'd0;
  localparam logic [2:0] StExists   = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StDeleted  = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StFound    = 3'd5;
  localparam logic [2:0] StListed   = 3'd6;
  localparam logic [2:0] StEmpty    = 3'd7;

  typedef struct packed {
    logic [2:0]       status;
    logic [HeadW-1:0] entry_head;
    logic [TailW-1:0] entry_tail;
    logic [CntW-1:0]  entry_total;
    logic             last;
  } rsp_t;

  // Zero every character after the first zero character; tail in the top byte.
  function automatic logic [NameW-1:0] canon_name(input logic [HeadW-1:0] head,
                                                  input logic [TailW-1:0] tail);
    logic [HeadW-1:0] h;
    logic             ended;
    h     = '0;
    ended = 1'b0;
    for (int k = 0; k < HeadW / 8; k++) begin
      if (head[8*k +: 8] == 8'd0) ended = 1'b1;
      if (!ended) h[8*k +: 8] = head[8*k +: 8];
    end
    return {(ended ? {TailW{1'b0}} : tail), h};
  endfunction

endpackage

>>> hdl/unt_if.sv
interface unt_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [unt_pkg::HeadW-1:0] key_head;
  logic [unt_pkg::TailW-1:0] key_tail;

  modport source (output valid, mode, key_head, key_tail, input ready);
  modport sink   (input valid, mode, key_head, key_tail, output ready);
endinterface

interface unt_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [unt_pkg::HeadW-1:0] entry_head;
  logic [unt_pkg::TailW-1:0] entry_tail;
  logic [unt_pkg::CntW-1:0]  entry_total;
  logic                     last;

  modport source (output valid, status, entry_head, entry_tail, entry_total, last,
                  input ready);
  modport sink   (input valid, status, entry_head, entry_tail, entry_total, last,
                  output ready);
endinterface

>>> hdl/unique_name_table.sv
// Ordered table of up to 16 unique nine-character names held in one 72-bit
// synchronous RAM. One request is handled at a time: req_i.ready is high only
// while the block is idle. Create, delete and search scan the table one entry
// per cycle through the RAM read port; a delete then moves each later entry
// down one place, reusing the same scan index. A list request emits one
// result per stored entry, one per cycle while the result side keeps up; an
// empty table gives a single result. Names are cut at their first zero
// character before being matched or stored. Results leave through a
// one-entry output register.
module unique_name_table (
  input  logic    clk_i,
  input  logic    rst_ni,
  unt_req_if.sink   req_i,
  unt_rsp_if.source rsp_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SShift = 3'd2;
  localparam logic [2:0] SList  = 3'd3;
  localparam logic [2:0] SEmit  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [1:0]                   mode_q, mode_d;
  logic [unt_pkg::NameW-1:0]    key_q, key_d;
  logic [unt_pkg::CntW-1:0]     idx_q, idx_d;
  logic [unt_pkg::CntW-1:0]     count_q, count_d;
  logic [2:0]                   st_q, st_d;

  logic                         we;
  logic [unt_pkg::IdxW-1:0]     waddr;
  logic [unt_pkg::NameW-1:0]    wdata;
  logic [unt_pkg::NameW-1:0]    rdata;
  logic                         out_load;
  logic                         out_free;
  unt_pkg::rsp_t                out_data;

  assign req_i.ready = (state_q == SIdle);

  // Read address follows the next index so read data always matches idx_q
  unt_ram #(
    .Width (unt_pkg::NameW),
    .Depth (unt_pkg::TableEntries)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_d[unt_pkg::IdxW-1:0]),
    .rdata_o (rdata)
  );

  // Sequence scan, compaction, listing and result emission
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    key_d    = key_q;
    idx_d    = idx_q;
    count_d  = count_q;
    st_d     = st_q;
    we       = 1'b0;
    waddr    = idx_q[unt_pkg::IdxW-1:0];
    wdata    = rdata;
    out_load = 1'b0;
    out_data = '{status: st_q, entry_head: '0, entry_tail: '0,
                 entry_total: count_q, last: 1'b1};
    case (state_q)
      SIdle: begin
        idx_d = '0;
        if (req_i.valid) begin
          mode_d = req_i.mode;
          key_d  = unt_pkg::canon_name(req_i.key_head, req_i.key_tail);
          if (req_i.mode == unt_pkg::ModeList) begin
            if (count_q == '0) begin
              st_d    = unt_pkg::StEmpty;
              state_d = SEmit;
            end else begin
              state_d = SList;
            end
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        if (idx_q == count_q) begin
          state_d = SEmit;
          if (mode_q == unt_pkg::ModeCreate) begin
            if (count_q == unt_pkg::CntW'(unt_pkg::TableEntries)) begin
              st_d = unt_pkg::StFull;
            end else begin
              we      = 1'b1;
              waddr   = count_q[unt_pkg::IdxW-1:0];
              wdata   = key_q;
              count_d = count_q + unt_pkg::CntW'(1);
              st_d    = unt_pkg::StCreated;
            end
          end else begin
            st_d = unt_pkg::StNotFound;
          end
        end else if (rdata == key_q) begin
          case (mode_q)
            unt_pkg::ModeCreate: begin
              st_d    = unt_pkg::StExists;
              state_d = SEmit;
            end
            unt_pkg::ModeDelete: begin
              idx_d   = idx_q + unt_pkg::CntW'(1);
              state_d = SShift;
            end
            default: begin
              st_d    = unt_pkg::StFound;
              state_d = SEmit;
            end
          endcase
        end else begin
          idx_d = idx_q + unt_pkg::CntW'(1);
        end
      end
      SShift: begin
        // Move each later entry down one place
        if (idx_q == count_q) begin
          count_d = count_q - unt_pkg::CntW'(1);
          st_d    = unt_pkg::StDeleted;
          state_d = SEmit;
        end else begin
          we    = 1'b1;
          waddr = idx_q[unt_pkg::IdxW-1:0] - unt_pkg::IdxW'(1);
          wdata = rdata;
          idx_d = idx_q + unt_pkg::CntW'(1);
        end
      end
      SList: begin
        out_data = '{status: unt_pkg::StListed,
                     entry_head: rdata[unt_pkg::HeadW-1:0],
                     entry_tail: rdata[unt_pkg::NameW-1:unt_pkg::HeadW],
                     entry_total: count_q,
                     last: ((idx_q + unt_pkg::CntW'(1)) == count_q)};
        if (out_free) begin
          out_load = 1'b1;
          if (out_data.last) begin
            state_d = SIdle;
          end else begin
            idx_d = idx_q + unt_pkg::CntW'(1);
          end
        end
      end
      SEmit: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
    st_q   <= st_d;
  end

  unt_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .data_i (out_data),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

endmodule

>>> hdl/unt_ram.sv
module unt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/unt_out_stage.sv
module unt_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  unt_pkg::rsp_t data_i,
  output logic          free_o,
  unt_rsp_if.source     rsp_o
);

  logic          valid_q, valid_d;
  unt_pkg::rsp_t data_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (rsp_o.ready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.status      = data_q.status;
  assign rsp_o.entry_head  = data_q.entry_head;
  assign rsp_o.entry_tail  = data_q.entry_tail;
  assign rsp_o.entry_total = data_q.entry_total;
  assign rsp_o.last        = data_q.last;

endmodule

>>> tb/unt_tb_pkg.sv
package unt_tb_pkg;
  import unt_pkg::*;

  // Track the name table and the results each request is owed
  class name_table_tracker;
    logic [NameW-1:0] names [TableEntries];
    int unsigned      stored;
    rsp_t             due_results [$];
    int unsigned      errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    // Cut a name at its first zero character; the ninth character goes on top
    function logic [NameW-1:0] trimmed(logic [HeadW-1:0] head, logic [TailW-1:0] tail);
      int               len;
      logic [HeadW-1:0] keep;
      len = HeadW / 8;
      for (int k = HeadW / 8 - 1; k >= 0; k--) begin
        if (head[8*k +: 8] == 8'h00) len = k;
      end
      if (len == HeadW / 8) return {tail, head};
      keep = (64'd1 << (8 * len)) - 64'd1;
      return {8'h00, head & keep};
    endfunction

    function int locate(logic [NameW-1:0] key);
      for (int i = 0; i < stored; i++) begin
        if (names[i] == key) return i;
      end
      return -1;
    endfunction

    // Apply one accepted request and queue the results it causes
    function void record_request(logic [1:0] mode, logic [HeadW-1:0] head,
                                 logic [TailW-1:0] tail);
      logic [NameW-1:0] key;
      int               pos;
      rsp_t             r;
      key    = trimmed(head, tail);
      pos    = locate(key);
      r      = '0;
      r.last = 1'b1;
      case (mode)
        ModeCreate: begin
          if (pos >= 0) begin
            r.status = StExists;
          end else if (stored >= TableEntries) begin
            r.status = StFull;
          end else begin
            names[stored] = key;
            stored++;
            r.status = StCreated;
          end
        end
        ModeDelete: begin
          if (pos >= 0) begin
            // close the gap, keep order
            for (int i = pos; i < stored - 1; i++) names[i] = names[i+1];
            stored--;
            r.status = StDeleted;
          end else begin
            r.status = StNotFound;
          end
        end
        ModeSearch: begin
          r.status = (pos >= 0) ? StFound : StNotFound;
        end
        default: begin
          if (stored == 0) begin
            r.status = StEmpty;
          end else begin
            // one result per stored entry, last one marked
            for (int i = 0; i < stored; i++) begin
              r.status      = StListed;
              r.entry_head  = names[i][HeadW-1:0];
              r.entry_tail  = names[i][NameW-1:HeadW];
              r.entry_total = CntW'(stored);
              r.last        = (i == stored - 1);
              due_results.push_back(r);
            end
            return;
          end
        end
      endcase
      r.entry_total = CntW'(stored);
      due_results.push_back(r);
    endfunction

    // Compare one accepted result against the oldest owed one
    function void match_result(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_head !== want.entry_head) begin
        $error("entry_head: expected %h, actual %h", want.entry_head, got.entry_head);
        errors++;
      end
      if (got.entry_tail !== want.entry_tail) begin
        $error("entry_tail: expected %h, actual %h", want.entry_tail, got.entry_tail);
        errors++;
      end
      if (got.entry_total !== want.entry_total) begin
        $error("entry_total: expected %0d, actual %0d", want.entry_total, got.entry_total);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

endpackage

>>> tb/tb_unique_name_table.sv
module tb_unique_name_table;
  import unt_pkg::*;
  import unt_tb_pkg::*;

  localparam int PoolSize   = 24;
  localparam int RandomReqs = 104;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n;
  bit   no_gaps;
  int   cycle_count;

  name_table_tracker tracker;

  logic [HeadW-1:0] pool_head [PoolSize];
  logic [TailW-1:0] pool_tail [PoolSize];
  int               pool_len  [PoolSize];

  unt_req_if req_bus ();
  unt_rsp_if rsp_bus ();

  unique_name_table DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #10 clk = ~clk;

  function int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 16);
  endfunction

  // Build the name pool: empty name, full nine 0xFF name, eight-character name, then random
  task build_pool();
    int len;
    pool_head[0] = '0;
    pool_tail[0] = '0;
    pool_len[0]  = 0;
    pool_head[1] = '1;
    pool_tail[1] = '1;
    pool_len[1]  = 9;
    for (int p = 2; p < PoolSize; p++) begin
      len          = (p == 2) ? 8 : $urandom_range(1, 9);
      pool_len[p]  = len;
      pool_head[p] = '0;
      for (int k = 0; k < 8; k++) begin
        if (k < len) pool_head[p][8*k +: 8] = 8'($urandom_range(1, 255));
      end
      pool_tail[p] = (len == 9) ? 8'($urandom_range(1, 255)) : 8'h00;
    end
  endtask

  // Present one request and hold it until it is accepted
  task send_request(logic [1:0] mode, logic [HeadW-1:0] head, logic [TailW-1:0] tail);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.mode     <= mode;
    req_bus.key_head <= head;
    req_bus.key_tail <= tail;
    do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
    tracker.record_request(mode, head, tail);
  endtask

  // Send a pool name, optionally with junk after its terminating zero
  task send_named(logic [1:0] mode, int idx, bit garble);
    logic [HeadW-1:0] head;
    logic [HeadW-1:0] junk;
    logic [HeadW-1:0] keep;
    logic [TailW-1:0] tail;
    int               len;
    len  = pool_len[idx];
    head = pool_head[idx];
    tail = pool_tail[idx];
    if (garble && len < 8) begin
      junk = {$urandom, $urandom};
      keep = (len == 7) ? '1 : (64'd1 << (8 * (len + 1))) - 64'd1;
      head = head | (junk & ~keep);
      tail = 8'($urandom);
    end
    send_request(mode, head, tail);
  endtask

  // Drop valid and hold off until every owed result has arrived
  task drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  function logic [1:0] pick_mode(bit fill_phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < (fill_phase ? 50 : 25)) return ModeCreate;
    if (r < (fill_phase ? 65 : 60)) return ModeDelete;
    if (r < 85) return ModeSearch;
    return ModeList;
  endfunction

  // Result side: random ready stalls, check every accepted result
  initial begin : rsp_side
    int   gap;
    rsp_t got;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_bus.valid && rsp_bus.ready));
      got.status      = rsp_bus.status;
      got.entry_head  = rsp_bus.entry_head;
      got.entry_tail  = rsp_bus.entry_tail;
      got.entry_total = rsp_bus.entry_total;
      got.last        = rsp_bus.last;
      tracker.match_result(got);
    end
  end

  // Stop a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Request side: directed pass, then random traffic
  initial begin : req_side
    int idx;
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.mode     <= ModeCreate;
    req_bus.key_head <= '0;
    req_bus.key_tail <= '0;
    no_gaps          = 1'b0;
    tracker          = new();
    build_pool();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: list, search and delete miss
    send_request(ModeList, '0, '0);
    send_named(ModeSearch, 0, 1'b0);
    send_named(ModeDelete, 1, 1'b0);
    // empty name with a nonzero ninth character, then fill the table
    send_request(ModeCreate, '0, 8'hFF);
    for (int p = 1; p < TableEntries; p++) send_named(ModeCreate, p, p[0]);
    // full table, duplicate on a full table, full listing
    send_named(ModeCreate, TableEntries, 1'b0);
    send_named(ModeCreate, 1, 1'b0);
    send_request(ModeList, '1, '1);
    // delete middle, first and last; search with junk past the end
    send_named(ModeDelete, 7, 1'b1);
    send_named(ModeDelete, 0, 1'b0);
    send_named(ModeDelete, TableEntries - 1, 1'b0);
    send_named(ModeSearch, 7, 1'b0);
    send_named(ModeSearch, 3, 1'b1);
    send_request(ModeList, '0, '0);
    drain();

    for (int n = 0; n < RandomReqs; n++) begin
      if (n % 25 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (n == RandomReqs / 2) drain();
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary name bits
        send_request(2'($urandom), {$urandom, $urandom}, 8'($urandom));
      end else begin
        idx = $urandom_range(0, PoolSize - 1);
        send_named(pick_mode(n < RandomReqs / 2), idx, 1'($urandom));
      end
    end
    drain();
    repeat (40) @(posedge clk);

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
